// ----- rtl/tile_min_mip_refcount_engine_core_assert.svh -----
// Assertion macros used by the refcount engine back end.
`ifndef TILE_MIN_MIP_REFCOUNT_ENGINE_CORE_ASSERT_SVH
`define TILE_MIN_MIP_REFCOUNT_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet in reset.
`define TMMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet in reset.
`define TMMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tmmr_pkg.sv -----
// Shared types, constants and address helpers of the refcount engine.
package tmmr_pkg;

  localparam int COORD_W = 6;
  localparam int LVL_W   = 3;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX    = 13'd8191;
  localparam logic [LVL_W-1:0] LEVEL_NONE = 3'd7;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  localparam logic [IDX_W-1:0] CFG_MIPS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDE = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HIGH = 2'd2;

  typedef struct packed {
    logic [LVL_W-1:0] mips;   // effective, already clamped to the level limit
    logic [CFG_W-1:0] wide;
    logic [CFG_W-1:0] high;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0]   cur;
    logic [LVL_W-1:0]   want;
  } job_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0]   level;
    logic               last;
  } res_t;

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(res_t);

  // First count of each level in the packed count store (levels shrink by 4x).
  function automatic logic [CNT_W-1:0] level_base(input logic [LVL_W-1:0] l);
    logic [CNT_W-1:0] b;
    case (l)
      3'd0:    b = 13'd0;
      3'd1:    b = 13'd4096;
      3'd2:    b = 13'd5120;
      3'd3:    b = 13'd5376;
      3'd4:    b = 13'd5440;
      3'd5:    b = 13'd5456;
      3'd6:    b = 13'd5460;
      default: b = 13'd5461;
    endcase
    return b;
  endfunction

  // Count address of the tile covering base tile (x, y) at level l.
  function automatic logic [CNT_W-1:0] cnt_addr(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [LVL_W-1:0]   l);
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [LVL_W-1:0] sh;
    sh  = 3'd6 - l;
    row = CNT_W'(y >> l) << sh;
    col = CNT_W'(x >> l);
    return level_base(l) + row + col;
  endfunction

endpackage

// ----- rtl/tmmr_fifo.sv -----
// Small flop-based queue used between the engine's parts.
module tmmr_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tmmr_front.sv -----
// Front end: accepts entries, drops out-of-grid ones, owns the mip cache.
module tmmr_front #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tmmr_pkg::cfg_t               cfg,
  input  logic                         push,
  output logic                         in_ready,
  input  logic [tmmr_pkg::COORD_W-1:0] tile_x,
  input  logic [tmmr_pkg::COORD_W-1:0] tile_y,
  input  logic [7:0]                   wanted_level,
  output logic                         job_push,
  output tmmr_pkg::job_t               job,
  input  logic                         job_full
);

  localparam int GH          = (GRID_H > 64) ? 64 : GRID_H;
  localparam int CACHE_DEPTH = GH * 64;
  localparam int CA          = $clog2(CACHE_DEPTH);
  localparam logic [8:0] GW9 = 9'(GRID_W);
  localparam logic [8:0] GH9 = 9'(GRID_H);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_LOOK = 1'b1;

  logic [tmmr_pkg::LVL_W-1:0]   cache [CACHE_DEPTH];
  logic [tmmr_pkg::LVL_W-1:0]   rdq;
  logic                         state;
  logic                         clearing;
  logic [CA-1:0]                clr_idx;
  logic [CA-1:0]                idx;
  logic [tmmr_pkg::COORD_W-1:0] x;
  logic [tmmr_pkg::COORD_W-1:0] y;
  logic [tmmr_pkg::LVL_W-1:0]   want;

  logic                         in_rng;
  logic                         go;
  logic [tmmr_pkg::LVL_W-1:0]   want_c;
  logic [tmmr_pkg::LVL_W-1:0]   cur;
  logic                         no_walk;
  logic                         fin;
  logic [11:0]                  full_idx;
  logic                         c_we;
  logic [CA-1:0]                c_wa;
  logic [tmmr_pkg::LVL_W-1:0]   c_wd;

  assign in_ready = (state == F_IDLE) && !clearing;
  assign in_rng   = ({1'b0, tile_x} < cfg.wide) && ({1'b0, tile_y} < cfg.high) &&
                    ({3'b0, tile_x} < GW9) && ({3'b0, tile_y} < GH9);
  assign go       = push && in_ready && in_rng;
  assign want_c   = (wanted_level > {5'b0, cfg.mips}) ? cfg.mips : wanted_level[2:0];
  assign full_idx = {tile_y, tile_x};

  // stale entries from a larger mip setting read as the current limit
  assign cur      = (rdq > cfg.mips) ? cfg.mips : rdq;
  assign no_walk  = (cur == want);
  assign fin      = (state == F_LOOK) && (no_walk || !job_full);
  assign job_push = (state == F_LOOK) && !no_walk && !job_full;
  assign job      = '{x: x, y: y, cur: cur, want: want};

  assign c_we = clearing || fin;
  assign c_wa = clearing ? clr_idx : idx;
  assign c_wd = clearing ? tmmr_pkg::LEVEL_NONE : want;

  always_ff @(posedge clk) begin
    if (c_we) begin
      cache[c_wa] <= c_wd;
    end
    if (go) begin
      rdq <= cache[full_idx[CA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x    <= tile_x;
      y    <= tile_y;
      want <= want_c;
      idx  <= full_idx[CA-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CA'(CACHE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        F_IDLE: begin
          if (go) begin
            state <= F_LOOK;
          end
        end
        F_LOOK: begin
          if (fin) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/tmmr_back.sv -----
// Back end: walks the mip chain with one count read-modify-write per level.
`include "tile_min_mip_refcount_engine_core_assert.svh"

module tmmr_back #(
  parameter int MAX_LEVELS = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_empty,
  input  tmmr_pkg::job_t job,
  output logic           job_pop,
  input  logic           res_full,
  output logic           res_push,
  output tmmr_pkg::res_t res_data
);

  localparam int LV          = (MAX_LEVELS > 7) ? 7 : MAX_LEVELS;
  localparam int COUNT_DEPTH = int'(tmmr_pkg::level_base(3'(LV)));
  localparam int CW          = $clog2(COUNT_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [tmmr_pkg::CNT_W-1:0]   counts [COUNT_DEPTH];
  logic [tmmr_pkg::CNT_W-1:0]   rdq;
  logic [1:0]                   state;
  logic                         clearing;
  logic [CW-1:0]                clr_idx;
  logic [tmmr_pkg::COORD_W-1:0] x;
  logic [tmmr_pkg::COORD_W-1:0] y;
  logic [tmmr_pkg::LVL_W-1:0]   want;
  logic [tmmr_pkg::LVL_W-1:0]   s;
  logic [tmmr_pkg::LVL_W-1:0]   lvl;
  logic                         down;
  tmmr_pkg::res_t               pend;
  logic                         pend_valid;

  logic [tmmr_pkg::LVL_W-1:0]   first_lvl;
  logic                         hit;
  logic                         stall;
  logic                         step;
  logic [tmmr_pkg::LVL_W-1:0]   s_nx;
  logic [tmmr_pkg::LVL_W-1:0]   nxt_lvl;
  logic                         done;
  logic [tmmr_pkg::CNT_W-1:0]   cnt_new;
  logic [tmmr_pkg::CNT_W-1:0]   wa_full;
  logic [tmmr_pkg::CNT_W-1:0]   ra_full;
  logic                         m_we;
  logic [CW-1:0]                m_wa;
  logic [tmmr_pkg::CNT_W-1:0]   m_wd;
  logic                         m_re;
  tmmr_pkg::res_t               new_res;

  assign job_pop   = (state == ST_IDLE) && !clearing && !job_empty;
  assign first_lvl = (job.cur > job.want) ? job.cur - 1'b1 : job.cur;

  // load when a count leaves zero, evict when it reaches zero
  assign hit   = down ? (rdq == '0) : (rdq == 13'd1);
  assign stall = hit && pend_valid && res_full;
  assign step  = (state == ST_WALK) && !stall;
  assign s_nx  = down ? lvl : s + 1'b1;
  assign done  = (s_nx == want);
  assign nxt_lvl = down ? s_nx - 1'b1 : s_nx;

  always_comb begin
    if (down) begin
      cnt_new = (rdq == tmmr_pkg::CNT_MAX) ? rdq : rdq + 1'b1;
    end else begin
      cnt_new = (rdq == '0) ? rdq : rdq - 1'b1;
    end
  end

  assign wa_full = tmmr_pkg::cnt_addr(x, y, lvl);
  assign ra_full = job_pop ? tmmr_pkg::cnt_addr(job.x, job.y, first_lvl)
                           : tmmr_pkg::cnt_addr(x, y, nxt_lvl);
  assign m_we = clearing || step;
  assign m_wa = clearing ? clr_idx : wa_full[CW-1:0];
  assign m_wd = clearing ? '0 : cnt_new;
  assign m_re = job_pop || (step && !done);

  assign new_res = '{kind:  down ? tmmr_pkg::KIND_LOAD : tmmr_pkg::KIND_EVICT,
                     x:     x >> lvl,
                     y:     y >> lvl,
                     level: lvl,
                     last:  1'b0};

  assign res_push = (step && hit && pend_valid) ||
                    ((state == ST_FIN) && pend_valid && !res_full);
  assign res_data = '{kind: pend.kind, x: pend.x, y: pend.y, level: pend.level,
                      last: (state == ST_FIN)};

  always_ff @(posedge clk) begin
    if (m_we) begin
      counts[m_wa] <= m_wd;
    end
    if (m_re) begin
      rdq <= counts[ra_full[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      x    <= job.x;
      y    <= job.y;
      want <= job.want;
      s    <= job.cur;
      lvl  <= first_lvl;
      down <= (job.cur > job.want);
    end else if (step) begin
      s   <= s_nx;
      lvl <= nxt_lvl;
    end
    if (step && hit) begin
      pend <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      clearing   <= 1'b1;
      clr_idx    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CW'(COUNT_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (step) begin
            if (hit) begin
              pend_valid <= 1'b1;
            end
            if (done) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (!res_full) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TMMR_ASSERT_IMP(a_job_has_walk, job_pop, job.cur != job.want, "job with nothing to walk")
  `TMMR_ASSERT_IMP(a_res_room, res_push, !res_full, "result word pushed into full queue")
  `TMMR_ASSERT_IMP(a_walk_dir, state == ST_WALK, down ? (s > want) : (s < want), "walk overran")
  `TMMR_ASSERT_NXT(a_fin_drain, (state == ST_FIN) && !(pend_valid && res_full), (state == ST_IDLE) && !pend_valid, "held word not flushed")

endmodule

// ----- rtl/tile_min_mip_refcount_engine_core.sv -----
// Top level of the tile min-mip reference count engine.
//
// Input channel: a feedback word (tile_x, tile_y, wanted_level) is taken on a
// clock edge with push high and full low. Result channel: while empty is low
// the oldest request word sits on request_kind/req_x/req_y/req_level/last and
// leaves on an edge with pop high. last marks the final word caused by an
// entry; an entry that changes nothing, or lies off the grid, gives no word.
// Config: cfg_we writes cfg_data into register cfg_index (0 mips in use,
// 1 tiles wide, 2 tiles high) at once; write only while the engine is idle.
// Flow: the front end takes a new entry only once the last one is handed off
// (cache read, then cache write and hand-off into a 4-deep job queue, held
// while that queue is full). The back end walks an entry over n mip levels
// (up to 7): a pop, one count read-modify-write per level on the single count
// memory, and a flush of the last word.
// Reset: rst clears control state and starts clearing passes: one over the
// 64*min(GRID_H,64) cache entries (4096 by default), with full held high,
// and one level-packed sweep over the counts (5461 by default) before jobs run.
// Stall: when pop is held low the 4-deep output queue fills, the back end holds
// its walk, the job queue fills, and full rises; no word is lost.
module tile_min_mip_refcount_engine_core #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int MAX_LEVELS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  // feedback input
  input  logic                         push,
  output logic                         full,
  input  logic [tmmr_pkg::COORD_W-1:0] tile_x,
  input  logic [tmmr_pkg::COORD_W-1:0] tile_y,
  input  logic [7:0]                   wanted_level,
  // request output
  output logic                         empty,
  input  logic                         pop,
  output logic                         request_kind,
  output logic [tmmr_pkg::COORD_W-1:0] req_x,
  output logic [tmmr_pkg::COORD_W-1:0] req_y,
  output logic [tmmr_pkg::LVL_W-1:0]   req_level,
  output logic                         last,
  // register writes
  input  logic                         cfg_we,
  input  logic [tmmr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tmmr_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [3:0] MAXL = 4'(MAX_LEVELS);

  logic [tmmr_pkg::LVL_W-1:0] mips_in_use;
  logic [tmmr_pkg::CFG_W-1:0] tiles_wide;
  logic [tmmr_pkg::CFG_W-1:0] tiles_high;
  tmmr_pkg::cfg_t             cfg;

  logic                       in_ready;
  logic                       job_push;
  tmmr_pkg::job_t             job_in;
  logic                       job_full;
  logic                       job_empty;
  logic                       job_pop;
  logic [tmmr_pkg::JOB_W-1:0] job_q_out;
  tmmr_pkg::job_t             job_out;
  logic                       res_full;
  logic                       res_push;
  tmmr_pkg::res_t             res_in;
  logic [tmmr_pkg::RES_W-1:0] res_q_out;
  tmmr_pkg::res_t             res_out;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      mips_in_use <= 3'd7;
      tiles_wide  <= 7'd64;
      tiles_high  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        tmmr_pkg::CFG_MIPS: mips_in_use <= cfg_data[2:0];
        tmmr_pkg::CFG_WIDE: tiles_wide  <= cfg_data;
        tmmr_pkg::CFG_HIGH: tiles_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // the mip count doubles as the none-referenced level, clamped to what is stored
  assign cfg.mips = ({1'b0, mips_in_use} > MAXL) ? MAXL[2:0] : mips_in_use;
  assign cfg.wide = tiles_wide;
  assign cfg.high = tiles_high;

  assign full = !in_ready;

  tmmr_front #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .in_ready     (in_ready),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .wanted_level (wanted_level),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full)
  );

  tmmr_fifo #(
    .WIDTH (tmmr_pkg::JOB_W),
    .DEPTH (4)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_q_out),
    .empty   (job_empty)
  );

  assign job_out = tmmr_pkg::job_t'(job_q_out);

  tmmr_back #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  tmmr_fifo #(
    .WIDTH (tmmr_pkg::RES_W),
    .DEPTH (4)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q_out),
    .empty   (empty)
  );

  assign res_out      = tmmr_pkg::res_t'(res_q_out);
  assign request_kind = res_out.kind;
  assign req_x        = res_out.x;
  assign req_y        = res_out.y;
  assign req_level    = res_out.level;
  assign last         = res_out.last;

endmodule

// ----- sim/tile_min_mip_refcount_engine_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the tile min-mip refcount engine core.
module tile_min_mip_refcount_engine_core_test;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int MAX_LEVELS = 7;

  // Engine is idle well inside this once the last request word is out.
  localparam int SETTLE_CYCLES = 64;
  // Cycles with no word moving on either side before we give up. Reset
  // clearing, with full high over the mip cache pass, must fit inside it.
  localparam int QUIET_LIMIT   = 40000;
  localparam int PHASES        = 6;
  localparam int WORDS_A_PHASE = 20;

  typedef enum logic { ROW_FEED, ROW_CFG } row_kind_t;
  // How a directed row is checked: by the predictor, no word at all, or one
  // word typed into the row.
  typedef enum logic [1:0] { CHECK_MODEL, CHECK_NONE, CHECK_ONE } row_check_t;

  typedef struct packed {
    row_kind_t                    kind;
    row_check_t                   check;
    logic [tmmr_pkg::IDX_W-1:0]   reg_idx;
    logic [tmmr_pkg::CFG_W-1:0]   reg_val;
    logic [tmmr_pkg::COORD_W-1:0] x;
    logic [tmmr_pkg::COORD_W-1:0] y;
    logic [7:0]                   w;
    tmmr_pkg::res_t               word;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         push         = 1'b0;
  logic                         full;
  logic [tmmr_pkg::COORD_W-1:0] tile_x       = '0;
  logic [tmmr_pkg::COORD_W-1:0] tile_y       = '0;
  logic [7:0]                   wanted_level = '0;
  logic                         empty;
  logic                         pop          = 1'b0;
  logic                         request_kind;
  logic [tmmr_pkg::COORD_W-1:0] req_x;
  logic [tmmr_pkg::COORD_W-1:0] req_y;
  logic [tmmr_pkg::LVL_W-1:0]   req_level;
  logic                         last;
  logic                         cfg_we       = 1'b0;
  logic [tmmr_pkg::IDX_W-1:0]   cfg_index    = '0;
  logic [tmmr_pkg::CFG_W-1:0]   cfg_data     = '0;

  // Predictor state: register copies, mip cache and per-level counts.
  logic [tmmr_pkg::LVL_W-1:0] cfg_mips = 3'd7;
  logic [tmmr_pkg::CFG_W-1:0] cfg_wide = 7'd64;
  logic [tmmr_pkg::CFG_W-1:0] cfg_high = 7'd64;
  logic [tmmr_pkg::LVL_W-1:0] tile_level [GRID_H][GRID_W];
  logic [tmmr_pkg::CNT_W-1:0] tile_refs  [MAX_LEVELS][GRID_H][GRID_W];

  tmmr_pkg::res_t due_requests [$];
  plan_row_t      plan [$];
  tmmr_pkg::res_t head_word;

  int fail_count   = 0;
  int quiet_cycles = 0;
  int send_idle    = 38;
  int recv_idle    = 80;

  // Per-phase register settings for the random part; extremes included.
  int phase_mips [PHASES] = '{7, 1, 4, 7, 2, 6};
  int phase_wide [PHASES] = '{64, 1, 8, 3, 64, 37};
  int phase_high [PHASES] = '{64, 1, 5, 64, 2, 17};

  always #1 clk = ~clk;

  tile_min_mip_refcount_engine_core #(
    .GRID_W    (GRID_W),
    .GRID_H    (GRID_H),
    .MAX_LEVELS(MAX_LEVELS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .wanted_level(wanted_level),
    .empty       (empty),
    .pop         (pop),
    .request_kind(request_kind),
    .req_x       (req_x),
    .req_y       (req_y),
    .req_level   (req_level),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    for (int j = 0; j < GRID_H; j++) begin
      for (int i = 0; i < GRID_W; i++) begin
        tile_level[j][i] = tmmr_pkg::LEVEL_NONE;
        for (int l = 0; l < MAX_LEVELS; l++) tile_refs[l][j][i] = '0;
      end
    end
  end

  // Walk the mip chain for one feedback word and queue the requests it makes.
  // Going finer: count up coarse to fine, load when a count leaves zero.
  // Going coarser: count down fine to coarse, evict when a count hits zero.
  // With keep low only the state moves (row has its own expectation).
  task automatic walk_mip_chain(input logic [tmmr_pkg::COORD_W-1:0] x,
                                input logic [tmmr_pkg::COORD_W-1:0] y,
                                input logic [7:0] w, input bit keep);
    logic [tmmr_pkg::LVL_W-1:0] lim;
    logic [tmmr_pkg::LVL_W-1:0] cur;
    logic [tmmr_pkg::LVL_W-1:0] want;
    logic [tmmr_pkg::LVL_W-1:0] s;
    tmmr_pkg::res_t             r;
    tmmr_pkg::res_t             made [$];
    if (x >= cfg_wide || x >= GRID_W || y >= cfg_high || y >= GRID_H) return;
    lim  = (cfg_mips > MAX_LEVELS) ? tmmr_pkg::LVL_W'(MAX_LEVELS) : cfg_mips;
    want = (w > lim) ? lim : w[tmmr_pkg::LVL_W-1:0];
    cur  = tile_level[y][x];
    // stale cache after a register change reads as the current limit
    if (cur > lim) cur = lim;
    s = cur;
    while (s > want) begin
      s = s - 1'b1;
      if (tile_refs[s][y >> s][x >> s] == '0) begin
        r = '{kind: tmmr_pkg::KIND_LOAD, x: x >> s, y: y >> s, level: s,
              last: 1'b0};
        made = {made, r};
      end
      // saturate at the top
      if (tile_refs[s][y >> s][x >> s] < tmmr_pkg::CNT_MAX)
        tile_refs[s][y >> s][x >> s] = tile_refs[s][y >> s][x >> s] + 1'b1;
    end
    while (s < want) begin
      if (tile_refs[s][y >> s][x >> s] == tmmr_pkg::CNT_W'(1)) begin
        r = '{kind: tmmr_pkg::KIND_EVICT, x: x >> s, y: y >> s, level: s,
              last: 1'b0};
        made = {made, r};
      end
      // a count already at zero stays there, quietly
      if (tile_refs[s][y >> s][x >> s] != '0)
        tile_refs[s][y >> s][x >> s] = tile_refs[s][y >> s][x >> s] - 1'b1;
      s = s + 1'b1;
    end
    tile_level[y][x] = want;
    if (made.size() != 0) made[made.size()-1].last = 1'b1;
    if (keep) foreach (made[k]) due_requests = {due_requests, made[k]};
  endtask

  // One feedback word: optional gap, then hold push until full lets it in.
  // Leaves push high; the next call lowers it or reloads it.
  task automatic send_word(input logic [tmmr_pkg::COORD_W-1:0] x,
                           input logic [tmmr_pkg::COORD_W-1:0] y,
                           input logic [7:0] w, input bit keep);
    if ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    push         <= 1'b1;
    tile_x       <= x;
    tile_y       <= y;
    wanted_level <= w;
    do @(posedge clk); while (full);
    walk_mip_chain(x, y, w, keep);
  endtask

  // Stop feeding, let every expected word out, then give the walk time to end
  // (entries that change nothing make no word to wait on).
  task automatic settle();
    push <= 1'b0;
    while (due_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tmmr_pkg::IDX_W-1:0] idx, input int val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= tmmr_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tmmr_pkg::CFG_MIPS: cfg_mips = tmmr_pkg::LVL_W'(val);
      tmmr_pkg::CFG_WIDE: cfg_wide = tmmr_pkg::CFG_W'(val);
      tmmr_pkg::CFG_HIGH: cfg_high = tmmr_pkg::CFG_W'(val);
      default: ;
    endcase
  endtask

  function automatic void plan_feed(input int x, input int y, input int w);
    plan_row_t row;
    row = '0;
    row.kind = ROW_FEED;
    row.check = CHECK_MODEL;
    row.x = tmmr_pkg::COORD_W'(x);
    row.y = tmmr_pkg::COORD_W'(y);
    row.w = 8'(w);
    plan = {plan, row};
  endfunction

  function automatic void plan_quiet(input int x, input int y, input int w);
    plan_feed(x, y, w);
    plan[plan.size()-1].check = CHECK_NONE;
  endfunction

  function automatic void plan_one(input int x, input int y, input int w, input logic kind,
                                   input int rx, input int ry, input int rl);
    plan_feed(x, y, w);
    plan[plan.size()-1].check = CHECK_ONE;
    plan[plan.size()-1].word  = '{kind: kind, x: tmmr_pkg::COORD_W'(rx),
                                  y: tmmr_pkg::COORD_W'(ry),
                                  level: tmmr_pkg::LVL_W'(rl), last: 1'b1};
  endfunction

  function automatic void plan_cfg(input logic [tmmr_pkg::IDX_W-1:0] idx, input int val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = tmmr_pkg::CFG_W'(val);
    plan = {plan, row};
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: random pop, each word taken is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_requests.size() == 0) begin
          $error("request word with nothing expected: kind %0d x %0d y %0d level %0d",
                 request_kind, req_x, req_y, req_level);
          fail_count++;
        end else begin
          head_word = due_requests.pop_front();
          check_field("request_kind", 8'(head_word.kind), 8'(request_kind));
          check_field("req_x", 8'(head_word.x), 8'(req_x));
          check_field("req_y", 8'(head_word.y), 8'(req_y));
          check_field("req_level", 8'(head_word.level), 8'(req_level));
          check_field("last", 8'(head_word.last), 8'(last));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** tile_min_mip_refcount_engine_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                           taken;
    int                           span_x;
    int                           span_y;
    int                           pick;
    logic [tmmr_pkg::COORD_W-1:0] rx;
    logic [tmmr_pkg::COORD_W-1:0] ry;
    logic [7:0]                   rw;

    // Directed rows. The first three depend on nothing else holding the
    // single level-6 tile, so they go first.
    plan_one(63, 63, 6, tmmr_pkg::KIND_LOAD, 0, 0, 6);   // fresh tile, one level finer
    plan_one(63, 63, 7, tmmr_pkg::KIND_EVICT, 0, 0, 6);  // and back again
    plan_quiet(63, 63, 255);                    // clamps to none-referenced: no walk
    plan_feed(0, 0, 0);                         // full walk, seven loads
    plan_quiet(0, 0, 0);                        // same level again: nothing
    plan_feed(63, 0, 0);
    plan_feed(0, 63, 3);
    plan_feed(0, 0, 8);                         // over-range wanted mip, clamped
    plan_feed(42, 21, 170);                     // alternating bit patterns
    plan_feed(21, 42, 85);
    plan_cfg(tmmr_pkg::CFG_WIDE, 10);
    plan_cfg(tmmr_pkg::CFG_HIGH, 20);
    plan_quiet(10, 5, 0);                       // off grid in x
    plan_quiet(9, 20, 0);                       // off grid in y
    plan_feed(9, 19, 0);                        // last tile inside
    plan_cfg(tmmr_pkg::CFG_MIPS, 3);
    plan_feed(0, 0, 0);                         // stale cache entry read as 3
    plan_feed(0, 0, 7);
    plan_cfg(tmmr_pkg::CFG_MIPS, 0);
    plan_quiet(1, 1, 5);                        // zero mips: walks nothing, caches 0
    plan_cfg(tmmr_pkg::CFG_MIPS, 7);
    plan_cfg(tmmr_pkg::CFG_WIDE, 64);
    plan_cfg(tmmr_pkg::CFG_HIGH, 64);
    plan_feed(1, 1, 7);                         // long coarsening walk
    plan_feed(0, 0, 7);                         // decrements at zero on the way up

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].x, plan[i].y, plan[i].w, plan[i].check == CHECK_MODEL);
        if (plan[i].check == CHECK_ONE) due_requests = {due_requests, plan[i].word};
      end
    end

    // Random phases: a few tiles near the origin get hit often so counts are
    // shared and walks go both ways; the rest is spread over the grid, with
    // some words off it and some raw wanted mips of any value.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(tmmr_pkg::CFG_MIPS, phase_mips[p]);
      write_reg(tmmr_pkg::CFG_WIDE, phase_wide[p]);
      write_reg(tmmr_pkg::CFG_HIGH, phase_high[p]);
      if (p < 2) begin
        send_idle = 38;
        recv_idle = 80;
      end else if (p < 4) begin
        send_idle = 80;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      span_x = (cfg_wide > GRID_W) ? GRID_W : cfg_wide;
      span_y = (cfg_high > GRID_H) ? GRID_H : cfg_high;
      taken = 0;
      while (taken < WORDS_A_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          rx = tmmr_pkg::COORD_W'($urandom_range(0, 63));
          ry = tmmr_pkg::COORD_W'($urandom_range(0, 63));
        end else if (pick < 6) begin
          rx = tmmr_pkg::COORD_W'($urandom_range(0, ((span_x < 4) ? span_x : 4) - 1));
          ry = tmmr_pkg::COORD_W'($urandom_range(0, ((span_y < 4) ? span_y : 4) - 1));
        end else begin
          rx = tmmr_pkg::COORD_W'($urandom_range(0, span_x - 1));
          ry = tmmr_pkg::COORD_W'($urandom_range(0, span_y - 1));
        end
        if ($urandom_range(0, 9) == 0) rw = 8'($urandom_range(0, 255));
        else rw = 8'($urandom_range(0, cfg_mips + 1));
        if (rx < cfg_wide && ry < cfg_high) taken++;
        send_word(rx, ry, rw, 1'b1);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("** tile_min_mip_refcount_engine_core: PASSED **");
    end else begin
      $display("** tile_min_mip_refcount_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
